/* rtl/core/pid_controller_clamped_core_assert.svh */
// Assertion macros shared by the core.
`ifndef PID_CONTROLLER_CLAMPED_CORE_ASSERT_SVH
`define PID_CONTROLLER_CLAMPED_CORE_ASSERT_SVH

// Checked only outside reset.
`define PIDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define PIDC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/pidc_pkg.sv */
package pidc_pkg;

  localparam int PIDC_DATA_WIDTH = 32;
  localparam int PIDC_FRAC_BITS  = 16;
  localparam int PIDC_MAX_W      = 48;  // widest supported DATA_WIDTH
  localparam int PIDC_FIELD_W    = 32;

  typedef logic [2:0] cfg_idx_t;
  typedef logic [1:0] action_t;

  // register indexes
  localparam cfg_idx_t REG_GAIN_P    = 3'd0;
  localparam cfg_idx_t REG_GAIN_I    = 3'd1;
  localparam cfg_idx_t REG_GAIN_D    = 3'd2;
  localparam cfg_idx_t REG_INT_LIMIT = 3'd3;
  localparam cfg_idx_t REG_OUT_LIMIT = 3'd4;
  localparam cfg_idx_t REG_STEP_TIME = 3'd5;
  localparam cfg_idx_t REG_STEP_RATE = 3'd6;

  // actions
  localparam action_t ACT_ERR_DERIV  = 2'd0;
  localparam action_t ACT_MEAS_DERIV = 2'd1;
  localparam action_t ACT_EXT_RATE   = 2'd2;
  localparam action_t ACT_CLEAR      = 2'd3;

  // Saturate a 33-bit signed value into a w-bit signed range.
  // Result is sign extended to PIDC_MAX_W bits; callers keep the low w bits.
  function automatic logic signed [PIDC_MAX_W-1:0] pidc_narrow(
    input logic signed [32:0] v,
    input int unsigned        w
  );
    logic signed [PIDC_MAX_W:0] x;
    logic signed [PIDC_MAX_W:0] vmax;
    logic signed [PIDC_MAX_W:0] vmin;
    logic        [PIDC_MAX_W:0] one;
    one  = (PIDC_MAX_W+1)'(1);
    x    = (PIDC_MAX_W+1)'(v);
    vmax = signed'((one << (w - 1)) - one);
    vmin = -vmax - signed'(one);
    if (x > vmax) begin
      x = vmax;
    end else if (x < vmin) begin
      x = vmin;
    end
    return x[PIDC_MAX_W-1:0];
  endfunction

endpackage

/* rtl/core/pidc_mul.sv */
// Bit-serial signed fractional multiplier: one multiplier bit per cycle.
// product = sat(floor(a * b / 2^FRAC_BITS)).
module pidc_mul
  import pidc_pkg::*;
#(
  parameter int DATA_WIDTH = PIDC_DATA_WIDTH,
  parameter int FRAC_BITS  = PIDC_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [DATA_WIDTH-1:0] a,
  input  logic signed [DATA_WIDTH-1:0] b,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] product
);

  localparam int DW    = DATA_WIDTH;
  localparam int CNT_W = $clog2(DW);

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_RUN  = 2'd1;
  localparam logic [1:0] M_FIN  = 2'd2;
  localparam logic [1:0] M_DONE = 2'd3;

  localparam logic [2*DW-1:0] FMASK = {{(2*DW-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

  logic [1:0]             state_r;
  logic [1:0]             state_nxt;
  logic [CNT_W-1:0]       cnt_r;
  logic [DW-1:0]          mcand_r;
  logic [DW-1:0]          hi_r;
  logic [DW-1:0]          lo_r;
  logic                   neg_r;
  logic signed [DW-1:0]   res_r;

  logic [DW-1:0]   a_mag;
  logic [DW-1:0]   b_mag;
  logic [DW:0]     step_sum;
  logic [2*DW-1:0] full_p;
  logic [2*DW-1:0] shifted;
  logic            round_up;
  logic            hi_nz;
  logic [DW:0]     q_t;
  logic [DW-1:0]   q_lim;
  logic [DW-1:0]   q_mag;

  assign a_mag = a[DW-1] ? (DW)'(-a) : a;
  assign b_mag = b[DW-1] ? (DW)'(-b) : b;

  assign step_sum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, mcand_r} : '0);

  // floor on negative products: round the magnitude up when bits drop
  assign full_p   = {hi_r, lo_r};
  assign shifted  = full_p >> FRAC_BITS;
  assign round_up = neg_r & (|(full_p & FMASK));
  assign hi_nz    = |shifted[2*DW-1:DW];
  assign q_t      = {1'b0, shifted[DW-1:0]} + (DW+1)'(round_up);
  assign q_lim    = neg_r ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
  assign q_mag    = (hi_nz || (q_t > {1'b0, q_lim})) ? q_lim : q_t[DW-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      M_IDLE:  if (start) state_nxt = M_RUN;
      M_RUN:   if (cnt_r == '0) state_nxt = M_FIN;
      M_FIN:   state_nxt = M_DONE;
      M_DONE:  state_nxt = M_IDLE;
      default: state_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      M_IDLE: begin
        if (start) begin
          mcand_r <= a_mag;
          lo_r    <= b_mag;
          hi_r    <= '0;
          neg_r   <= a[DW-1] ^ b[DW-1];
          cnt_r   <= CNT_W'(DW - 1);
        end
      end
      M_RUN: begin
        hi_r  <= step_sum[DW:1];
        lo_r  <= {step_sum[0], lo_r[DW-1:1]};
        cnt_r <= cnt_r - 1'b1;
      end
      M_FIN: begin
        res_r <= neg_r ? signed'((DW)'(-q_mag)) : signed'(q_mag);
      end
      default: ;
    endcase
  end

  assign done    = (state_r == M_DONE);
  assign product = res_r;

endmodule

/* rtl/core/pidc_cfg.sv */
// Configuration register bank; values are narrowed to DATA_WIDTH on write.
module pidc_cfg
  import pidc_pkg::*;
#(
  parameter int DATA_WIDTH = PIDC_DATA_WIDTH,
  parameter int FRAC_BITS  = PIDC_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  cfg_idx_t                      wr_index,
  input  logic [PIDC_FIELD_W-1:0]       wr_data,
  output logic signed [DATA_WIDTH-1:0]  gain_p,
  output logic signed [DATA_WIDTH-1:0]  gain_i,
  output logic signed [DATA_WIDTH-1:0]  gain_d,
  output logic signed [DATA_WIDTH-1:0]  int_limit,
  output logic signed [DATA_WIDTH-1:0]  out_limit,
  output logic signed [DATA_WIDTH-1:0]  step_time,
  output logic signed [DATA_WIDTH-1:0]  step_rate
);

  localparam int DW = DATA_WIDTH;
  localparam logic signed [PIDC_MAX_W-1:0] ONE_W =
    pidc_narrow(signed'(33'(1) << FRAC_BITS), DW);
  localparam logic signed [DW-1:0] ONE_Q = ONE_W[DW-1:0];

  logic signed [PIDC_MAX_W-1:0] sval_w;
  logic signed [PIDC_MAX_W-1:0] uval_w;
  logic signed [DW-1:0]         sval;
  logic signed [DW-1:0]         uval;

  logic signed [DW-1:0] gain_p_r;
  logic signed [DW-1:0] gain_i_r;
  logic signed [DW-1:0] gain_d_r;
  logic signed [DW-1:0] int_limit_r;
  logic signed [DW-1:0] out_limit_r;
  logic signed [DW-1:0] step_time_r;
  logic signed [DW-1:0] step_rate_r;

  assign sval_w = pidc_narrow(signed'({wr_data[31], wr_data}), DW);
  assign uval_w = pidc_narrow(signed'({2'b00, wr_data[30:0]}), DW);
  assign sval   = sval_w[DW-1:0];
  assign uval   = uval_w[DW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r    <= '0;
      gain_i_r    <= '0;
      gain_d_r    <= '0;
      int_limit_r <= '0;
      out_limit_r <= '0;
      step_time_r <= ONE_Q;
      step_rate_r <= ONE_Q;
    end else if (wr_en) begin
      case (wr_index)
        REG_GAIN_P:    gain_p_r    <= sval;
        REG_GAIN_I:    gain_i_r    <= sval;
        REG_GAIN_D:    gain_d_r    <= sval;
        REG_INT_LIMIT: int_limit_r <= uval;
        REG_OUT_LIMIT: out_limit_r <= uval;
        REG_STEP_TIME: step_time_r <= uval;
        REG_STEP_RATE: step_rate_r <= uval;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  assign gain_p    = gain_p_r;
  assign gain_i    = gain_i_r;
  assign gain_d    = gain_d_r;
  assign int_limit = int_limit_r;
  assign out_limit = out_limit_r;
  assign step_time = step_time_r;
  assign step_rate = step_rate_r;

endmodule

/* rtl/core/pid_controller_clamped_core.sv */
// Sequence (accept to out_valid): the two difference derivative modes run five
// products, the external rate mode four, and clear none.
// A new sample is accepted only once the sequencer is idle again; the bit-serial
// multiplier (up to five products per transaction) sets the pace.
// Reset (rst_n low, synchronous): registers back to defaults, state cleared.
`include "pid_controller_clamped_core_assert.svh"

module pid_controller_clamped_core
  import pidc_pkg::*;
#(
  parameter int DATA_WIDTH = PIDC_DATA_WIDTH,
  parameter int FRAC_BITS  = PIDC_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  cfg_idx_t                       cfg_index,
  input  logic [PIDC_FIELD_W-1:0]        cfg_data,
  // sample channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  action_t                        in_action,
  input  logic signed [PIDC_FIELD_W-1:0] in_measure,
  input  logic signed [PIDC_FIELD_W-1:0] in_target,
  input  logic signed [PIDC_FIELD_W-1:0] in_rate_in,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [PIDC_FIELD_W-1:0] out_drive
);

  localparam int DW = DATA_WIDTH;

  localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};

  // Sequencer. Each ALU step is a single state; each multiply state holds
  // until the serial multiplier reports done.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ERR   = 4'd1;   // error = target - measure
  localparam logic [3:0] S_MDT   = 4'd2;   // error * step_time
  localparam logic [3:0] S_IACC  = 4'd3;   // integral + product
  localparam logic [3:0] S_ICLP  = 4'd4;   // clamp integral
  localparam logic [3:0] S_MP    = 4'd5;   // gain_p * error
  localparam logic [3:0] S_MI    = 4'd6;   // gain_i * integral
  localparam logic [3:0] S_ADDI  = 4'd7;   // drive += integral term
  localparam logic [3:0] S_DIFF  = 4'd8;   // error or measure difference
  localparam logic [3:0] S_MRATE = 4'd9;   // difference * step_rate
  localparam logic [3:0] S_MD    = 4'd10;  // gain_d * derivative
  localparam logic [3:0] S_ADDD  = 4'd11;  // drive +/- derivative term
  localparam logic [3:0] S_OCLP  = 4'd12;  // clamp output
  localparam logic [3:0] S_OUT   = 4'd13;  // hand result to output register

  // Saturating add or subtract.
  function automatic logic signed [DW-1:0] sat_sum(
    input logic signed [DW-1:0] x,
    input logic signed [DW-1:0] y,
    input logic                 sub
  );
    logic signed [DW:0] s;
    s = sub ? ((DW+1)'(x) - (DW+1)'(y)) : ((DW+1)'(x) + (DW+1)'(y));
    if (s[DW] != s[DW-1]) begin
      return s[DW] ? VMIN : VMAX;
    end
    return s[DW-1:0];
  endfunction

  // Symmetric clamp; lim is never negative.
  function automatic logic signed [DW-1:0] clamp_sym(
    input logic signed [DW-1:0] x,
    input logic signed [DW-1:0] lim
  );
    if (x > lim) begin
      return lim;
    end
    if (x < -lim) begin
      return -lim;
    end
    return x;
  endfunction

  // configuration
  logic signed [DW-1:0] gain_p;
  logic signed [DW-1:0] gain_i;
  logic signed [DW-1:0] gain_d;
  logic signed [DW-1:0] int_limit;
  logic signed [DW-1:0] out_limit;
  logic signed [DW-1:0] step_time;
  logic signed [DW-1:0] step_rate;

  assign cfg_ready = 1'b1;

  pidc_cfg #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (cfg_valid & cfg_ready),
    .wr_index  (cfg_index),
    .wr_data   (cfg_data),
    .gain_p    (gain_p),
    .gain_i    (gain_i),
    .gain_d    (gain_d),
    .int_limit (int_limit),
    .out_limit (out_limit),
    .step_time (step_time),
    .step_rate (step_rate)
  );

  // sequencer and datapath registers
  logic [3:0]           state_r;
  logic [3:0]           state_nxt;
  action_t              act_r;
  logic signed [DW-1:0] meas_r;
  logic signed [DW-1:0] targ_r;
  logic signed [DW-1:0] rate_r;
  logic signed [DW-1:0] err_r;
  logic signed [DW-1:0] tmp_r;
  logic signed [DW-1:0] drv_r;
  logic signed [DW-1:0] integ_r;
  logic signed [DW-1:0] perr_r;
  logic signed [DW-1:0] pmeas_r;
  logic                 mul_pend_r;
  logic                 out_valid_r;
  logic signed [PIDC_FIELD_W-1:0] out_drive_r;

  logic                 in_fire;
  logic                 out_load;
  logic                 is_mul;
  logic                 mul_start;
  logic                 mul_done;
  logic signed [DW-1:0] mul_a;
  logic signed [DW-1:0] mul_b;
  logic signed [DW-1:0] mul_p;
  logic signed [DW-1:0] alu_y;

  logic signed [PIDC_MAX_W-1:0] meas_w;
  logic signed [PIDC_MAX_W-1:0] targ_w;
  logic signed [PIDC_MAX_W-1:0] rate_w;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid & in_ready;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);

  // input fields narrowed (saturated) to DATA_WIDTH
  assign meas_w = pidc_narrow(signed'({in_measure[31], in_measure}), DW);
  assign targ_w = pidc_narrow(signed'({in_target[31], in_target}), DW);
  assign rate_w = pidc_narrow(signed'({in_rate_in[31], in_rate_in}), DW);

  // multiplier operand select
  always_comb begin
    is_mul = 1'b1;
    mul_a  = err_r;
    mul_b  = step_time;
    case (state_r)
      S_MDT: begin
        mul_a = err_r;
        mul_b = step_time;
      end
      S_MP: begin
        mul_a = gain_p;
        mul_b = err_r;
      end
      S_MI: begin
        mul_a = gain_i;
        mul_b = integ_r;
      end
      S_MRATE: begin
        mul_a = tmp_r;
        mul_b = step_rate;
      end
      S_MD: begin
        mul_a = gain_d;
        mul_b = (act_r == ACT_EXT_RATE) ? rate_r : tmp_r;
      end
      default: is_mul = 1'b0;
    endcase
  end

  assign mul_start = is_mul & ~mul_pend_r;

  pidc_mul #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_p)
  );

  // single shared add / clamp unit
  always_comb begin
    alu_y = '0;
    case (state_r)
      S_ERR:  alu_y = sat_sum(targ_r, meas_r, 1'b1);
      S_IACC: alu_y = sat_sum(integ_r, tmp_r, 1'b0);
      S_ICLP: alu_y = clamp_sym(tmp_r, int_limit);
      S_ADDI: alu_y = sat_sum(drv_r, tmp_r, 1'b0);
      S_DIFF: alu_y = (act_r == ACT_ERR_DERIV) ? sat_sum(err_r, perr_r, 1'b1)
                                                : sat_sum(pmeas_r, meas_r, 1'b1);
      S_ADDD: alu_y = sat_sum(drv_r, tmp_r, act_r == ACT_EXT_RATE);
      S_OCLP: alu_y = clamp_sym(drv_r, out_limit);
      default: alu_y = '0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_ERR;
      S_ERR:   state_nxt = (act_r == ACT_CLEAR) ? S_OUT : S_MDT;
      S_MDT:   if (mul_done) state_nxt = S_IACC;
      S_IACC:  state_nxt = S_ICLP;
      S_ICLP:  state_nxt = S_MP;
      S_MP:    if (mul_done) state_nxt = S_MI;
      S_MI:    if (mul_done) state_nxt = S_ADDI;
      S_ADDI:  state_nxt = (act_r == ACT_EXT_RATE) ? S_MD : S_DIFF;
      S_DIFF:  state_nxt = S_MRATE;
      S_MRATE: if (mul_done) state_nxt = S_MD;
      S_MD:    if (mul_done) state_nxt = S_ADDD;
      S_ADDD:  state_nxt = S_OCLP;
      S_OCLP:  state_nxt = S_OUT;
      S_OUT:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mul_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (mul_start) begin
        mul_pend_r <= 1'b1;
      end else if (mul_done) begin
        mul_pend_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // controller state carried between transactions
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
      perr_r  <= '0;
      pmeas_r <= '0;
    end else begin
      case (state_r)
        S_ERR: begin
          if (act_r == ACT_CLEAR) begin
            integ_r <= '0;
            perr_r  <= '0;
            pmeas_r <= '0;
          end
        end
        S_ICLP: integ_r <= alu_y;
        S_ADDD: begin
          if (act_r == ACT_ERR_DERIV) perr_r <= err_r;
          if (act_r == ACT_MEAS_DERIV) pmeas_r <= meas_r;
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r  <= in_action;
      meas_r <= meas_w[DW-1:0];
      targ_r <= targ_w[DW-1:0];
      rate_r <= rate_w[DW-1:0];
    end
    case (state_r)
      S_ERR: begin
        err_r <= alu_y;
        drv_r <= '0;  // clear action leaves zero here
      end
      S_MDT, S_MI, S_MRATE, S_MD: if (mul_done) tmp_r <= mul_p;
      S_MP:   if (mul_done) drv_r <= mul_p;
      S_IACC: tmp_r <= alu_y;
      S_ADDI: drv_r <= alu_y;
      S_DIFF: tmp_r <= alu_y;
      S_ADDD: drv_r <= alu_y;
      S_OCLP: drv_r <= alu_y;
      default: ;
    endcase
    if (out_load) begin
      out_drive_r <= PIDC_FIELD_W'(drv_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_drive = out_drive_r;

  `PIDC_ASSERT(a_accept_starts_seq, in_fire |=> (state_r == S_ERR), "accepted sample did not start sequencer")
  `PIDC_ASSERT(a_result_from_seq, $rose(out_valid_r) |-> ($past(state_r) == S_OUT), "result raised outside output step")
  `PIDC_ASSERT(a_mul_done_owned, mul_done |-> mul_pend_r, "multiplier finished with no pending request")
  `PIDC_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> (state_r == S_IDLE && !out_valid_r && !mul_pend_r), "core not idle after reset")

endmodule
